[rtl/core/stc_pkg.sv]
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants for the straight track chi2 block
// Word layouts, register indexes, status codes and saturation limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

  // hit limit per track and derived counter widths
  localparam int MAX_HITS    = 16;
  localparam int CNT_W       = $clog2(MAX_HITS + 1);
  localparam int DEN_W       = CNT_W + 1;

  // hit queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // saturation limits
  localparam logic [23:0] Q_MAX   = 24'hFF_FFFF;
  localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] OUT_MAX = 32'hFFFF_FFFF;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ORIGIN_X    = 3'd0,
    CFG_ORIGIN_Y    = 3'd1,
    CFG_SLOPE_X     = 3'd2,
    CFG_SLOPE_Y     = 3'd3,
    CFG_FIXED_ERROR = 3'd4
  } cfg_reg_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_FEW   = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  // input word
  typedef struct packed {
    logic signed [31:0] hit_z;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic        [23:0] err_x;
    logic        [23:0] err_y;
    logic               last_hit;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [31:0] chi2_total;
    logic [31:0] chi2_x;
    logic [31:0] chi2_y;
    logic [4:0]  hit_total;
    logic [1:0]  status;
  } out_word_t;

  // classified hit handed from front to back: residual magnitudes, chosen errors
  typedef struct packed {
    logic [36:0] mag_x;
    logic [36:0] mag_y;
    logic [23:0] err_x;
    logic [23:0] err_y;
    logic        last_hit;
  } hit_job_t;

endpackage

`default_nettype wire

[rtl/core/stc_fifo.sv]
// ----------------------------------------------------------------------------
// stc_fifo: hit job queue
// Small register queue that decouples the projection front from the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stc_fifo (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire stc_pkg::hit_job_t           push_data,
  input  wire logic                        pop,
  output stc_pkg::hit_job_t                pop_data,
  output logic                             pop_valid,
  output logic [stc_pkg::QPTR_W:0]         count
);

  stc_pkg::hit_job_t                 mem_r [stc_pkg::QUEUE_DEPTH];
  logic [stc_pkg::QPTR_W-1:0]        wr_ptr_r;
  logic [stc_pkg::QPTR_W-1:0]        rd_ptr_r;
  logic [stc_pkg::QPTR_W:0]          count_r;
  logic                              do_pop;

  assign pop_valid = (count_r != '0);
  assign do_pop    = pop && pop_valid;
  assign pop_data  = mem_r[rd_ptr_r];
  assign count     = count_r;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/stc_front.sv]
// ----------------------------------------------------------------------------
// stc_front: configuration and hit projection
// Holds the track registers, projects each hit and forms residual magnitudes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stc_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire stc_pkg::in_word_t           in_data,
  input  wire logic                        cfg_we,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [31:0]                 cfg_wdata,
  output logic                             push,
  output stc_pkg::hit_job_t                push_data,
  input  wire logic [stc_pkg::QPTR_W:0]    q_count
);

  logic signed [31:0] origin_x_r;
  logic signed [31:0] origin_y_r;
  logic signed [31:0] slope_x_r;
  logic signed [31:0] slope_y_r;
  logic        [23:0] fixed_error_r;

  logic               s1_valid_r;
  logic signed [63:0] prod_x_r;
  logic signed [63:0] prod_y_r;
  stc_pkg::in_word_t  hit_r;

  logic               accept;
  logic [37:0]        res_x;
  logic [37:0]        res_y;
  logic [37:0]        neg_x;
  logic [37:0]        neg_y;

  // hold off while the projection stage is full or the queue may not take it
  assign busy   = s1_valid_r ||
                  (q_count >= (stc_pkg::QPTR_W + 1)'(stc_pkg::QUEUE_DEPTH - 1));
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      slope_x_r     <= '0;
      slope_y_r     <= '0;
      fixed_error_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stc_pkg::CFG_ORIGIN_X:    origin_x_r    <= cfg_wdata;
        stc_pkg::CFG_ORIGIN_Y:    origin_y_r    <= cfg_wdata;
        stc_pkg::CFG_SLOPE_X:     slope_x_r     <= cfg_wdata;
        stc_pkg::CFG_SLOPE_Y:     slope_y_r     <= cfg_wdata;
        stc_pkg::CFG_FIXED_ERROR: fixed_error_r <= cfg_wdata[23:0];
        default:                  ;
      endcase
    end
  end

  // projection stage: slope times z, Q.36
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_x_r <= slope_x_r * in_data.hit_z;
      prod_y_r <= slope_y_r * in_data.hit_z;
      hit_r    <= in_data;
    end
  end

  // residual = meas - origin - floor(prod / 2^28), exact in Q.8
  always_comb begin
    res_x = {{6{hit_r.meas_x[31]}}, hit_r.meas_x}
          - {{6{origin_x_r[31]}}, origin_x_r}
          - {{2{prod_x_r[63]}}, prod_x_r[63:28]};
    res_y = {{6{hit_r.meas_y[31]}}, hit_r.meas_y}
          - {{6{origin_y_r[31]}}, origin_y_r}
          - {{2{prod_y_r[63]}}, prod_y_r[63:28]};
    neg_x = -res_x;
    neg_y = -res_y;
  end

  // classified word into the queue
  always_comb begin
    push               = s1_valid_r;
    push_data.mag_x    = res_x[37] ? neg_x[36:0] : res_x[36:0];
    push_data.mag_y    = res_y[37] ? neg_y[36:0] : res_y[36:0];
    push_data.err_x    = (fixed_error_r != '0) ? fixed_error_r : hit_r.err_x;
    push_data.err_y    = (fixed_error_r != '0) ? fixed_error_r : hit_r.err_y;
    push_data.last_hit = hit_r.last_hit;
  end

endmodule

`default_nettype wire

[rtl/core/stc_back.sv]
// ----------------------------------------------------------------------------
// stc_back: normalization, accumulation and track close
// Shared serial divider for hit ratios and final per-dof quotients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stc_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 job_valid,
  input  wire stc_pkg::hit_job_t    job_data,
  output logic                      job_pop,
  output logic                      out_valid,
  output stc_pkg::out_word_t        out_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PREP  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_SQR   = 8'b0000_1000,
    S_ACC   = 8'b0001_0000,
    S_CLOSE = 8'b0010_0000,
    S_FPREP = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t                    state_r, state_nxt;
  stc_pkg::hit_job_t         job_r;
  logic                      axis_r;
  logic [47:0]               sum_x_r;
  logic [47:0]               sum_y_r;
  logic [stc_pkg::CNT_W-1:0] cnt_r;
  logic                      sat_r;
  logic                      clamp_r;
  logic                      fin_r;
  logic [1:0]                sel_r;
  logic [24:0]               rem_r;
  logic [31:0]               low_r;
  logic [31:0]               quot_r;
  logic [23:0]               den_r;
  logic [5:0]                step_r;
  logic [23:0]               q_r;
  logic [47:0]               sq_r;
  logic [31:0]               res_tot_r;
  logic [31:0]               res_x_r;
  logic [31:0]               res_y_r;
  logic                      out_valid_r;
  stc_pkg::out_word_t        out_data_r;

  logic [36:0]               cur_mag;
  logic [23:0]               cur_err;
  logic [24:0]               trial;
  logic                      ge;
  logic [31:0]               quot_new;
  logic [48:0]               acc_sum;
  logic [48:0]               fin_num;
  logic [stc_pkg::DEN_W-1:0] fin_den;
  logic                      few;

  // per-axis operand select
  always_comb begin
    cur_mag = axis_r ? job_r.mag_y : job_r.mag_x;
    cur_err = axis_r ? job_r.err_y : job_r.err_x;
  end

  // one restoring divider step
  always_comb begin
    trial    = {rem_r[23:0], low_r[31]};
    ge       = (trial >= {1'b0, den_r});
    quot_new = {quot_r[30:0], ge};
  end

  // accumulation and final divide operands
  always_comb begin
    acc_sum = axis_r ? ({1'b0, sum_y_r} + {1'b0, sq_r})
                     : ({1'b0, sum_x_r} + {1'b0, sq_r});
    unique case (sel_r)
      2'd0:    fin_num = {1'b0, sum_x_r} + {1'b0, sum_y_r};
      2'd1:    fin_num = {1'b0, sum_x_r};
      default: fin_num = {1'b0, sum_y_r};
    endcase
    if (sel_r == 2'd0) begin
      fin_den = {cnt_r, 1'b0} - stc_pkg::DEN_W'(4);
    end else begin
      fin_den = stc_pkg::DEN_W'(cnt_r) - stc_pkg::DEN_W'(2);
    end
    few = (cnt_r <= stc_pkg::CNT_W'(2));
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (cnt_r >= stc_pkg::CNT_W'(stc_pkg::MAX_HITS)) begin
          state_nxt = S_CLOSE;
        end else if (cur_err == '0) begin
          state_nxt = axis_r ? S_CLOSE : S_PREP;
        end else if ({3'b0, cur_mag[36:16]} >= cur_err) begin
          state_nxt = S_SQR;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (step_r == 6'd1) begin
          if (!fin_r) begin
            state_nxt = S_SQR;
          end else begin
            state_nxt = (sel_r == 2'd2) ? S_OUT : S_FPREP;
          end
        end
      end
      S_SQR:   state_nxt = S_ACC;
      S_ACC:   state_nxt = axis_r ? S_CLOSE : S_PREP;
      S_CLOSE: begin
        if (!job_r.last_hit) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = few ? S_OUT : S_FPREP;
        end
      end
      S_FPREP: begin
        if ({7'b0, fin_num[48:32]} >= 24'(fin_den)) begin
          state_nxt = (sel_r == 2'd2) ? S_OUT : S_FPREP;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // track state: sums, hit count, flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      cnt_r   <= '0;
      sat_r   <= 1'b0;
      clamp_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_PREP: begin
          if (cnt_r >= stc_pkg::CNT_W'(stc_pkg::MAX_HITS)) begin
            sat_r <= 1'b1;
          end else if (cur_err == '0) begin
            sat_r <= 1'b1;
            if (axis_r) begin
              sum_y_r <= stc_pkg::SUM_MAX;
              cnt_r   <= cnt_r + 1'b1;
            end else begin
              sum_x_r <= stc_pkg::SUM_MAX;
            end
          end else if ({3'b0, cur_mag[36:16]} >= cur_err) begin
            sat_r <= 1'b1;
          end
        end
        S_ACC: begin
          if (acc_sum[48]) begin
            sat_r <= 1'b1;
          end
          if (axis_r) begin
            sum_y_r <= acc_sum[48] ? stc_pkg::SUM_MAX : acc_sum[47:0];
            cnt_r   <= cnt_r + 1'b1;
          end else begin
            sum_x_r <= acc_sum[48] ? stc_pkg::SUM_MAX : acc_sum[47:0];
          end
        end
        S_FPREP: begin
          if ({7'b0, fin_num[48:32]} >= 24'(fin_den)) begin
            clamp_r <= 1'b1;
          end
        end
        S_OUT: begin
          sum_x_r <= '0;
          sum_y_r <= '0;
          cnt_r   <= '0;
          sat_r   <= 1'b0;
          clamp_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath: job capture, divider, square, final quotients
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        job_r  <= job_data;
        axis_r <= 1'b0;
        fin_r  <= 1'b0;
        sel_r  <= 2'd0;
      end
      S_PREP: begin
        if (cur_err == '0) begin
          axis_r <= 1'b1;
        end else if ({3'b0, cur_mag[36:16]} >= cur_err) begin
          q_r <= stc_pkg::Q_MAX;
        end else begin
          rem_r  <= 25'(cur_mag[36:16]);
          low_r  <= {cur_mag[15:0], 16'b0};
          den_r  <= cur_err;
          quot_r <= '0;
          step_r <= 6'd24;
        end
      end
      S_DIV: begin
        rem_r  <= ge ? (trial - {1'b0, den_r}) : trial;
        low_r  <= {low_r[30:0], 1'b0};
        quot_r <= quot_new;
        step_r <= step_r - 1'b1;
        if (step_r == 6'd1) begin
          if (!fin_r) begin
            q_r <= quot_new[23:0];
          end else begin
            unique case (sel_r)
              2'd0:    res_tot_r <= quot_new;
              2'd1:    res_x_r   <= quot_new;
              default: res_y_r   <= quot_new;
            endcase
            sel_r <= sel_r + 1'b1;
          end
        end
      end
      S_SQR: sq_r <= q_r * q_r;
      S_ACC: axis_r <= 1'b1;
      S_CLOSE: begin
        fin_r <= 1'b1;
        sel_r <= 2'd0;
      end
      S_FPREP: begin
        if ({7'b0, fin_num[48:32]} >= 24'(fin_den)) begin
          unique case (sel_r)
            2'd0:    res_tot_r <= stc_pkg::OUT_MAX;
            2'd1:    res_x_r   <= stc_pkg::OUT_MAX;
            default: res_y_r   <= stc_pkg::OUT_MAX;
          endcase
          sel_r <= sel_r + 1'b1;
        end else begin
          rem_r  <= 25'(fin_num[48:32]);
          low_r  <= fin_num[31:0];
          den_r  <= 24'(fin_den);
          quot_r <= '0;
          step_r <= 6'd32;
        end
      end
      default: ;
    endcase
  end

  // result word, one cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT) begin
      out_data_r.chi2_total <= few ? '0 : res_tot_r;
      out_data_r.chi2_x     <= few ? '0 : res_x_r;
      out_data_r.chi2_y     <= few ? '0 : res_y_r;
      out_data_r.hit_total  <= 5'(cnt_r);
      if (few) begin
        out_data_r.status <= stc_pkg::ST_FEW;
      end else if (sat_r || clamp_r) begin
        out_data_r.status <= stc_pkg::ST_SAT;
      end else begin
        out_data_r.status <= stc_pkg::ST_VALID;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/core/straight_track_chi_square.sv]
// ----------------------------------------------------------------------------
// straight_track_chi_square: straight track fit quality
// Projects hits onto a configured line and sums normalized squared residuals.
// ----------------------------------------------------------------------------
//   channel  | handshake            | word
//   ---------+----------------------+------------------------------------
//   input    | start / busy         | in_data  (hit z, x, y, errors, last)
//   result   | out_valid (strobe)   | out_data (chi2 x/y/total, n, status)
//   config   | cfg_we, cfg_index    | cfg_wdata
//
// A hit takes two 24-step divisions in the back end on the
// shared serial divider plus square and accumulate; a clamped ratio skips
// its divide. A closing hit adds three 32-step quotients; a quotient that
// would overflow skips its divide. The front holds off a new hit while its
// projection stage is full or its 4-word queue holds three or more words.
// Reset is synchronous, active low, and clears the track state and the
// configuration. The receiver cannot stall: out_valid lasts one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module straight_track_chi_square (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire stc_pkg::in_word_t   in_data,
  output logic                     out_valid,
  output stc_pkg::out_word_t       out_data,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_wdata
);

  logic                          push;
  stc_pkg::hit_job_t             push_data;
  logic                          pop;
  stc_pkg::hit_job_t             pop_data;
  logic                          pop_valid;
  logic [stc_pkg::QPTR_W:0]      q_count;

  // projection front
  stc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_data (push_data),
    .q_count   (q_count)
  );

  // hit queue
  stc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .count     (q_count)
  );

  // divider back end
  stc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_data  (pop_data),
    .job_pop   (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // an accepted word occupies the projection stage for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low right after an accepted word");

  // results are isolated strobes
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // a short track reports zero chi2
  a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == stc_pkg::ST_FEW)) |->
    ((out_data.chi2_total == '0) && (out_data.chi2_x == '0) &&
     (out_data.chi2_y == '0)))
    else $error("too-few-hits result carries nonzero chi2");

  // the queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= (stc_pkg::QPTR_W + 1)'(stc_pkg::QUEUE_DEPTH))
    else $error("hit queue overflow");
`endif

endmodule

`default_nettype wire

[dv/straight_track_chi_square_checker.sv]
// ----------------------------------------------------------------------------
// straight_track_chi_square_checker: result predictor and scoreboard
// Follows accepted hit words and config writes, predicts the result of each
// closing hit and compares every out_valid word with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module straight_track_chi_square_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  stc_pkg::in_word_t   in_data,
  input  logic                out_valid,
  input  stc_pkg::out_word_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  output int                  fail_count,
  output int                  pending
);
  import stc_pkg::*;

  // shadow configuration
  logic signed [31:0] org_x, org_y, slp_x, slp_y;
  logic        [23:0] fix_err;

  // shadow track state
  logic [47:0] acc_x, acc_y;
  int          n_hits;
  bit          sat;

  out_word_t   chi2_q[$];

  assign pending = chi2_q.size();

  // add one normalized squared residual to a sum
  task automatic add_residual(inout logic [47:0] acc, input logic signed [31:0] org,
                              input logic signed [31:0] slp,
                              input logic signed [31:0] z,
                              input logic signed [31:0] meas, input logic [23:0] err);
    logic signed [63:0] prod, proj, res;
    logic [63:0] mag, q;
    logic [64:0] s;
    prod = 64'(slp) * 64'(z);
    proj = prod >>> 28;               // arithmetic shift is a floor
    res  = 64'(meas) - 64'(org) - proj;
    mag  = res[63] ? 64'(-res) : 64'(res);
    if (err == 0) begin
      acc = SUM_MAX;
      sat = 1;
    end else begin
      q = (mag << 8) / 64'(err);
      if (q > 64'(Q_MAX)) begin
        q = 64'(Q_MAX);
        sat = 1;
      end
      s = 65'(acc) + 65'(q * q);
      if (s > 65'(SUM_MAX)) begin
        acc = SUM_MAX;
        sat = 1;
      end else acc = s[47:0];
    end
  endtask

  function automatic logic [31:0] clamp_div(input logic [63:0] num, input logic [63:0] den,
                                            inout bit clamped);
    logic [63:0] v;
    v = num / den;
    if (v > 64'(OUT_MAX)) begin
      clamped = 1;
      return OUT_MAX;
    end
    return v[31:0];
  endfunction

  task automatic predict_hit(input in_word_t w);
    logic [23:0] ex, ey;
    out_word_t   r;
    bit          clamped;
    ex = w.err_x;
    ey = w.err_y;
    clamped = 0;
    if (fix_err != 0) begin
      ex = fix_err;
      ey = fix_err;
    end
    if (n_hits >= MAX_HITS) sat = 1;
    else begin
      add_residual(acc_x, org_x, slp_x, w.hit_z, w.meas_x, ex);
      add_residual(acc_y, org_y, slp_y, w.hit_z, w.meas_y, ey);
      n_hits++;
    end
    if (w.last_hit) begin
      r = '0;
      r.hit_total = 5'(n_hits);
      if (n_hits <= 2) r.status = ST_FEW;
      else begin
        r.chi2_total = clamp_div(64'(acc_x) + 64'(acc_y), 64'(2 * n_hits - 4), clamped);
        r.chi2_x     = clamp_div(64'(acc_x), 64'(n_hits - 2), clamped);
        r.chi2_y     = clamp_div(64'(acc_y), 64'(n_hits - 2), clamped);
        r.status     = (sat || clamped) ? ST_SAT : ST_VALID;
      end
      chi2_q.push_back(r);
      acc_x = 0; acc_y = 0; n_hits = 0; sat = 0;
    end
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      org_x <= 0; org_y <= 0; slp_x <= 0; slp_y <= 0; fix_err <= 0;
      acc_x = 0; acc_y = 0; n_hits = 0; sat = 0;
      chi2_q.delete();
      fail_count <= 0;
    end else begin
      // compare result word with the oldest prediction
      if (out_valid) begin
        if (chi2_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = chi2_q.pop_front();
          if (out_data.chi2_total !== e.chi2_total || out_data.chi2_x !== e.chi2_x ||
              out_data.chi2_y !== e.chi2_y || out_data.hit_total !== e.hit_total ||
              out_data.status !== e.status) begin
            $display("%0t: result mismatch, expected tot %h x %h y %h n %0d st %0d,",
                     $time, e.chi2_total, e.chi2_x, e.chi2_y, e.hit_total, e.status);
            $display("%0t:   actual tot %h x %h y %h n %0d st %0d", $time,
                     out_data.chi2_total, out_data.chi2_x, out_data.chi2_y,
                     out_data.hit_total, out_data.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) predict_hit(in_data);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ORIGIN_X:    org_x   <= cfg_wdata;
          CFG_ORIGIN_Y:    org_y   <= cfg_wdata;
          CFG_SLOPE_X:     slp_x   <= cfg_wdata;
          CFG_SLOPE_Y:     slp_y   <= cfg_wdata;
          CFG_FIXED_ERROR: fix_err <= cfg_wdata[23:0];
          default: ;
        endcase
      end
    end
  end
endmodule

[dv/straight_track_chi_square_tb.sv]
// ----------------------------------------------------------------------------
// straight_track_chi_square_tb: stimulus and verdict for the track chi2 block
// Runs directed and random tracks under several line and error settings with
// random input gaps; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module straight_track_chi_square_tb;
  import stc_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 400;

  logic      clk, rst_n, start, busy, out_valid, cfg_we;
  in_word_t  in_data;
  out_word_t out_data;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  int fail_count, pending, idle_cycles;

  straight_track_chi_square u_dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  straight_track_chi_square_checker u_chk (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // watchdog on cycles without any accepted word or result word
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for all predictions to come back, then let the back end settle
  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_hit(input in_word_t w);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk);
    start <= 1'b1; in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
  endtask

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [23:0] rnd_err();
    case ($urandom_range(0, 7))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      2: return 24'($urandom_range(1, 4));
      default: return 24'($urandom_range(64, 4096));
    endcase
  endfunction

  // mostly hits lying near the configured line with modest errors
  function automatic in_word_t near_hit(input logic last);
    in_word_t w;
    w.hit_z  = $urandom;
    w.meas_x = $urandom;
    w.meas_y = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      w.hit_z  = 32'(int'($urandom_range(0, 200000)) - 100000);
      w.meas_x = 32'(int'($urandom_range(0, 20000)) - 10000);
      w.meas_y = 32'(int'($urandom_range(0, 20000)) - 10000);
    end
    w.err_x = ($urandom_range(0, 9) == 0) ? rnd_err() : 24'($urandom_range(256, 65535));
    w.err_y = ($urandom_range(0, 9) == 0) ? rnd_err() : 24'($urandom_range(256, 65535));
    w.last_hit = last;
    return w;
  endfunction

  task automatic send_track(input int n);
    for (int i = 0; i < n; i++) send_hit(near_hit(i == n - 1));
  endtask

  in_word_t w;
  int sent, ntrk;

  initial begin
    rst_n = 1'b0; start = 1'b0; in_data = '0;
    cfg_we = 1'b0; cfg_index = CFG_ORIGIN_X; cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, few hits, zero error, overflow, too many hits
    w = '0; w.err_x = 24'd256; w.err_y = 24'd256;
    w.last_hit = 1; send_hit(w);                      // single hit
    w.last_hit = 0; send_hit(w); w.last_hit = 1; send_hit(w);   // two hits
    w.hit_z = 32'h7FFF_FFFF; w.meas_x = 32'h8000_0000; w.meas_y = 32'h7FFF_FFFF;
    w.err_x = 24'hFF_FFFF; w.err_y = 24'd1; w.last_hit = 0;
    send_hit(w); send_hit(w);
    w.err_x = 24'd0; w.last_hit = 1; send_hit(w);     // zero error and ratio clamp
    w = '0; w.meas_x = 32'd1000; w.meas_y = -32'sd1000;
    w.err_x = 24'd300; w.err_y = 24'd500;
    for (int i = 0; i < 18; i++) begin                // past the hit limit
      w.last_hit = (i == 17);
      send_hit(w);
    end
    settle();

    write_reg(CFG_ORIGIN_X, 32'h8000_0000);
    write_reg(CFG_ORIGIN_Y, 32'h7FFF_FFFF);
    write_reg(CFG_SLOPE_X, 32'h7FFF_FFFF);
    write_reg(CFG_SLOPE_Y, 32'h8000_0000);
    write_reg(CFG_FIXED_ERROR, 32'h00FF_FFFF);
    w = '0; w.hit_z = 32'h8000_0000; w.meas_x = 32'h7FFF_FFFF; w.meas_y = 32'h8000_0000;
    w.err_x = 24'hFF_FFFF; w.err_y = 24'hFF_FFFF;
    for (int i = 0; i < 4; i++) begin
      w.last_hit = (i == 3);
      send_hit(w);
    end
    settle();

    // random phases with changing line and error settings
    sent = 0;
    while (sent < 400) begin
      write_reg(CFG_ORIGIN_X, ($urandom_range(0, 3) == 0) ? rnd32()
                : 32'(int'($urandom_range(0, 2000)) - 1000));
      write_reg(CFG_ORIGIN_Y, ($urandom_range(0, 3) == 0) ? rnd32()
                : 32'(int'($urandom_range(0, 2000)) - 1000));
      write_reg(CFG_SLOPE_X, ($urandom_range(0, 3) == 0) ? rnd32()
                : 32'(int'($urandom_range(0, 1 << 26)) - (1 << 25)));
      write_reg(CFG_SLOPE_Y, ($urandom_range(0, 3) == 0) ? rnd32()
                : 32'(int'($urandom_range(0, 1 << 26)) - (1 << 25)));
      write_reg(CFG_FIXED_ERROR, ($urandom_range(0, 2) == 0) ? 32'(rnd_err()) : 32'd0);
      for (int t = 0; t < 6; t++) begin
        ntrk = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(3, 8);
        send_track(ntrk);
        sent += ntrk;
      end
      // occasional fully random word
      w = $bits(in_word_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
      send_hit(w); sent++;
      w.last_hit = 1; send_hit(w); sent++;
      settle();
    end

    settle();
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
